// ===== src/pim_pkg.sv =====
// ============================================================================
// pim_pkg
// Shared constants for the PWM input measurement core.
// ============================================================================
`default_nettype none

package pim_pkg;

    localparam int COUNTER_BITS_DEFAULT = 16;
    localparam int TPS_WIDTH            = 24;
    localparam int DUTY_WIDTH           = 7;

    localparam logic [TPS_WIDTH-1:0]  DEFAULT_TICK_RATE = 24'd1000000;
    localparam logic [DUTY_WIDTH-1:0] PERCENT_SCALE     = 7'd100;

    // edge sequence codes
    localparam logic [2:0] EDGE_WAIT_RISE1 = 3'd0;
    localparam logic [2:0] EDGE_WAIT_FALL1 = 3'd1;
    localparam logic [2:0] EDGE_WAIT_RISE2 = 3'd2;
    localparam logic [2:0] EDGE_WAIT_FALL2 = 3'd3;
    localparam logic [2:0] EDGE_DONE       = 3'd4;

endpackage

`default_nettype wire

// ===== src/pwm_input_measure_core.sv =====
// ============================================================================
// pwm_input_measure_core
// Throughput: one sample or start transfer per cycle while measuring.
// After the final-edge transfer the input stalls while one shared serial
// divider runs twice (duty, then frequency), DW = max(COUNTER_BITS+7, 24)
// quotient bits each, and until the result is taken into the output register;
// a zero period skips the divider. Reset: idle, not armed, rate = 1000000.
// ============================================================================
`default_nettype none

module pwm_input_measure_core #(
    parameter int COUNTER_BITS = pim_pkg::COUNTER_BITS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [pim_pkg::TPS_WIDTH-1:0]  cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           cmd,
    input  wire logic                           level,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [COUNTER_BITS-1:0]             high_ticks,
    output logic [COUNTER_BITS-1:0]             period_ticks,
    output logic [pim_pkg::DUTY_WIDTH-1:0]      duty_percent,
    output logic [pim_pkg::TPS_WIDTH-1:0]       frequency_value,
    output logic                                zero_period_error
);

    localparam int DW = (COUNTER_BITS + 7 > pim_pkg::TPS_WIDTH) ?
                        COUNTER_BITS + 7 : pim_pkg::TPS_WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DUTY = 2'd1;
    localparam logic [1:0] ST_FREQ = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [pim_pkg::TPS_WIDTH-1:0]    tps_reg;
    logic [COUNTER_BITS-1:0]          high_reg;
    logic [COUNTER_BITS-1:0]          period_reg;
    logic [pim_pkg::DUTY_WIDTH-1:0]   duty_reg;
    logic [pim_pkg::TPS_WIDTH-1:0]    freq_reg;
    logic                             err_reg;
    logic                             out_valid_reg;
    logic [COUNTER_BITS-1:0]          out_high_reg;
    logic [COUNTER_BITS-1:0]          out_period_reg;
    logic [pim_pkg::DUTY_WIDTH-1:0]   out_duty_reg;
    logic [pim_pkg::TPS_WIDTH-1:0]    out_freq_reg;
    logic                             out_err_reg;

    logic                             in_accept;
    logic                             meas_valid;
    logic [COUNTER_BITS-1:0]          meas_high;
    logic [COUNTER_BITS-1:0]          meas_period;
    logic                             div_start;
    logic [DW-1:0]                    div_dividend;
    logic                             div_done;
    logic [DW-1:0]                    div_quotient;
    logic [DW-1:0]                    high_x100;
    logic                             out_free;
    logic                             load;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid & ~in_stall;
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign load      = (state_reg == ST_LOAD) & out_free;

    // high * 100 = high*64 + high*32 + high*4
    assign high_x100 = (DW'(meas_high) << 6) + (DW'(meas_high) << 5) + (DW'(meas_high) << 2);

    pim_capture #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .cmd         (cmd),
        .level       (level),
        .meas_valid  (meas_valid),
        .meas_high   (meas_high),
        .meas_period (meas_period)
    );

    pim_div #(
        .DIVIDEND_BITS (DW),
        .DIVISOR_BITS  (COUNTER_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (meas_period),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = high_x100;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (meas_valid)
                begin
                    if (meas_period == '0)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DUTY;
                    end
                end
            end
            ST_DUTY:
            begin
                div_dividend = DW'(tps_reg);
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_FREQ;
                end
            end
            ST_FREQ:
            begin
                if (div_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tps_reg       <= pim_pkg::DEFAULT_TICK_RATE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                tps_reg <= cfg_wdata;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && meas_valid)
        begin
            high_reg   <= meas_high;
            period_reg <= meas_period;
            err_reg    <= (meas_period == '0);
            duty_reg   <= '0;
            freq_reg   <= '0;
        end
        if (state_reg == ST_DUTY && div_done)
        begin
            duty_reg <= (div_quotient > DW'(pim_pkg::PERCENT_SCALE)) ?
                        pim_pkg::PERCENT_SCALE : div_quotient[pim_pkg::DUTY_WIDTH-1:0];
        end
        if (state_reg == ST_FREQ && div_done)
        begin
            freq_reg <= div_quotient[pim_pkg::TPS_WIDTH-1:0];
        end
        if (load)
        begin
            out_high_reg   <= high_reg;
            out_period_reg <= period_reg;
            out_duty_reg   <= duty_reg;
            out_freq_reg   <= freq_reg;
            out_err_reg    <= err_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign high_ticks        = out_high_reg;
    assign period_ticks      = out_period_reg;
    assign duty_percent      = out_duty_reg;
    assign frequency_value   = out_freq_reg;
    assign zero_period_error = out_err_reg;

endmodule

`default_nettype wire

// ===== src/pim_capture.sv =====
// ============================================================================
// pim_capture
// Tick counter, edge detection and capture of the edge times; pulses one
// measurement (high time and period) at the second falling edge after the first rising edge following a start.
// ============================================================================
`default_nettype none

module pim_capture #(
    parameter int COUNTER_BITS = pim_pkg::COUNTER_BITS_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic                    cmd,
    input  wire logic                    level,
    output logic                         meas_valid,
    output logic [COUNTER_BITS-1:0]      meas_high,
    output logic [COUNTER_BITS-1:0]      meas_period
);

    logic [COUNTER_BITS-1:0] tick_reg;
    logic [2:0]              edge_reg;
    logic                    armed_reg;
    logic                    last_reg;
    logic [COUNTER_BITS-1:0] cap_fall1_reg;
    logic [COUNTER_BITS-1:0] cap_rise2_reg;
    logic                    meas_valid_reg;
    logic [COUNTER_BITS-1:0] meas_high_reg;
    logic [COUNTER_BITS-1:0] meas_period_reg;

    logic [COUNTER_BITS-1:0] tick_inc;
    logic                    rise;
    logic                    fall;

    assign tick_inc = tick_reg + {{(COUNTER_BITS-1){1'b0}}, 1'b1};
    assign rise     = level & ~last_reg;
    assign fall     = ~level & last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            edge_reg       <= pim_pkg::EDGE_WAIT_RISE1;
            armed_reg      <= 1'b0;
            last_reg       <= 1'b0;
            cap_fall1_reg  <= '0;
            cap_rise2_reg  <= '0;
            meas_valid_reg <= 1'b0;
        end
        else
        begin
            meas_valid_reg <= 1'b0;
            if (accept)
            begin
                if (cmd)
                begin
                    cap_fall1_reg <= '0;
                    cap_rise2_reg <= '0;
                    edge_reg      <= pim_pkg::EDGE_WAIT_RISE1;
                    armed_reg     <= 1'b1;
                end
                else
                begin
                    last_reg <= level;
                    if (armed_reg && edge_reg == pim_pkg::EDGE_WAIT_RISE1 && rise)
                    begin
                        tick_reg <= '0;
                        edge_reg <= pim_pkg::EDGE_WAIT_FALL1;
                    end
                    else
                    begin
                        tick_reg <= tick_inc;
                        if (armed_reg)
                        begin
                            if (edge_reg == pim_pkg::EDGE_WAIT_FALL1 && fall)
                            begin
                                cap_fall1_reg <= tick_inc;
                                edge_reg      <= pim_pkg::EDGE_WAIT_RISE2;
                            end
                            else if (edge_reg == pim_pkg::EDGE_WAIT_RISE2 && rise)
                            begin
                                cap_rise2_reg <= tick_inc;
                                edge_reg      <= pim_pkg::EDGE_WAIT_FALL2;
                            end
                            else if (edge_reg == pim_pkg::EDGE_WAIT_FALL2 && fall)
                            begin
                                edge_reg       <= pim_pkg::EDGE_DONE;
                                armed_reg      <= 1'b0;
                                meas_valid_reg <= 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !cmd && armed_reg && edge_reg == pim_pkg::EDGE_WAIT_FALL2 && fall)
        begin
            meas_high_reg   <= tick_inc - cap_rise2_reg;
            meas_period_reg <= tick_inc - cap_fall1_reg;
        end
    end

    assign meas_valid  = meas_valid_reg;
    assign meas_high   = meas_high_reg;
    assign meas_period = meas_period_reg;

endmodule

`default_nettype wire

// ===== src/pim_div.sv =====
// ============================================================================
// pim_div
// Bit-serial restoring divider: one quotient bit per cycle, DIVIDEND_BITS
// quotient bits per division, done pulse when the quotient is final.
// ============================================================================
`default_nettype none

module pim_div #(
    parameter int DIVIDEND_BITS = 24,
    parameter int DIVISOR_BITS  = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic                          done,
    output logic [DIVIDEND_BITS-1:0]      quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [DIVIDEND_BITS-1:0] dvd_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  dvs_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    assign trial = {rem_reg, dvd_reg[DIVIDEND_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(DIVIDEND_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - {{(CNT_BITS-1){1'b0}}, 1'b1};
                if (cnt_reg == {{(CNT_BITS-1){1'b0}}, 1'b1})
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIVIDEND_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
